// ===== sv/slcd_pkg.sv =====
// shared types and constants for the sync, length and checksum deframer
package slcd_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned POS_W   = 6;
   localparam int unsigned LEN_W   = 7;
   localparam int unsigned CSR_IDX_W = 1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND = 1'd1;

   // frame handover from the receive side to the burst reader
   typedef struct packed {
      logic             start;
      logic [LEN_W-1:0] length;
   } slcd_burst_type;

endpackage

// ===== sv/slcd_ram.sv =====
// generic simple dual-port ram with registered read
module slcd_ram #(
   parameter int unsigned WIDTH  = 8,
   parameter int unsigned DEPTH  = 64,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/slcd_rx.sv =====
// receive side: sync hunt, length check, payload store writes and checksums
module slcd_rx #(
   parameter int unsigned MAX_PAYLOAD = 64,
   parameter int unsigned ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           byte_valid,
   input  logic [slcd_pkg::BYTE_W-1:0]    rx_byte,
   input  logic [slcd_pkg::BYTE_W-1:0]    sync_first,
   input  logic [slcd_pkg::BYTE_W-1:0]    sync_second,
   output logic                           wr_en,
   output logic [ADDR_W-1:0]              wr_addr,
   output logic [slcd_pkg::BYTE_W-1:0]    wr_data,
   output slcd_pkg::slcd_burst_type       burst
);
   import slcd_pkg::*;

   localparam logic [2:0] PH_SYNC1 = 3'd0;
   localparam logic [2:0] PH_SYNC2 = 3'd1;
   localparam logic [2:0] PH_LEN   = 3'd2;
   localparam logic [2:0] PH_DATA  = 3'd3;
   localparam logic [2:0] PH_CK1   = 3'd4;
   localparam logic [2:0] PH_CK2   = 3'd5;

   localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_PAYLOAD);

   logic [2:0]        phase_ff,  phase_in;
   logic [LEN_W-1:0]  exp_len_ff, exp_len_in;
   logic [LEN_W-1:0]  count_ff,  count_in;
   logic [BYTE_W-1:0] sum_lo_ff, sum_lo_in;
   logic [BYTE_W-1:0] sum_hi_ff, sum_hi_in;
   logic [LEN_W-1:0]  count_inc;

   assign count_inc = count_ff + LEN_W'(1);

   always_comb begin
      phase_in   = phase_ff;
      exp_len_in = exp_len_ff;
      count_in   = count_ff;
      sum_lo_in  = sum_lo_ff;
      sum_hi_in  = sum_hi_ff;
      wr_en      = 1'b0;
      burst      = '0;
      if (byte_valid) begin
         unique case (phase_ff)
            PH_SYNC2: begin
               phase_in = (rx_byte == sync_second) ? PH_LEN : PH_SYNC1;
            end
            PH_LEN: begin
               if (rx_byte == '0 || rx_byte > MAX_LEN) begin
                  phase_in = PH_SYNC1;
               end else begin
                  exp_len_in = rx_byte[LEN_W-1:0];
                  count_in   = '0;
                  sum_lo_in  = rx_byte;
                  sum_hi_in  = rx_byte;
                  phase_in   = PH_DATA;
               end
            end
            PH_DATA: begin
               wr_en     = 1'b1;
               count_in  = count_inc;
               sum_lo_in = sum_lo_ff + rx_byte;
               sum_hi_in = sum_hi_ff + sum_lo_in;
               if (count_inc >= exp_len_ff) begin
                  phase_in = PH_CK1;
               end
            end
            PH_CK1: begin
               phase_in = (rx_byte == sum_lo_ff) ? PH_CK2 : PH_SYNC1;
            end
            PH_CK2: begin
               phase_in     = PH_SYNC1;
               burst.start  = (rx_byte == sum_hi_ff);
               burst.length = exp_len_ff;
            end
            default: begin
               // hunting, and any unused phase code behaves the same
               phase_in = (rx_byte == sync_first) ? PH_SYNC2 : PH_SYNC1;
            end
         endcase
      end
   end

   assign wr_addr = count_ff[ADDR_W-1:0];
   assign wr_data = rx_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SYNC1;
         exp_len_ff <= '0;
         count_ff   <= '0;
         sum_lo_ff  <= '0;
         sum_hi_ff  <= '0;
      end else begin
         phase_ff   <= phase_in;
         exp_len_ff <= exp_len_in;
         count_ff   <= count_in;
         sum_lo_ff  <= sum_lo_in;
         sum_hi_ff  <= sum_hi_in;
      end
   end

`ifndef SYNTHESIS
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> count_ff < exp_len_ff)
      else $error("payload write beyond frame length");

   a_len_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> (exp_len_ff != '0 && exp_len_ff <= LEN_W'(MAX_PAYLOAD)))
      else $error("stored length out of range");

   a_start_after_ck1: assert property (@(posedge clock) disable iff (reset)
      burst.start |-> $past(phase_ff) == PH_CK1 || $past(phase_ff) == PH_CK2)
      else $error("burst start without first check byte");
`endif

endmodule

// ===== sv/slcd_tx.sv =====
// burst reader: walks the payload store and drives the result register
module slcd_tx #(
   parameter int unsigned MAX_PAYLOAD = 64,
   parameter int unsigned ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  slcd_pkg::slcd_burst_type       burst,
   output logic                           busy,
   output logic                           rd_en,
   output logic [ADDR_W-1:0]              rd_addr,
   input  logic [slcd_pkg::BYTE_W-1:0]    rd_data,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [slcd_pkg::BYTE_W-1:0]    out_byte,
   output logic [slcd_pkg::POS_W-1:0]     out_pos,
   output logic [slcd_pkg::LEN_W-1:0]     out_len,
   output logic                           out_last
);
   import slcd_pkg::*;

   logic              active_ff,  active_in;
   logic              pending_ff, pending_in;
   logic              valid_ff,   valid_in;
   logic [LEN_W-1:0]  len_ff,     len_in;
   logic [LEN_W-1:0]  idx_ff,     idx_in;
   logic [POS_W-1:0]  pend_pos_ff, pend_pos_in;
   logic [BYTE_W-1:0] byte_ff,    byte_in;
   logic [POS_W-1:0]  pos_ff,     pos_in;
   logic [LEN_W-1:0]  len_out_ff, len_out_in;
   logic              last_ff,    last_in;
   logic [LEN_W-1:0]  idx_inc;

   assign idx_inc = idx_ff + LEN_W'(1);

   // one read in flight at a time, issued only when the result register frees up
   assign rd_en   = active_ff && !pending_ff && (!valid_ff || out_ready);
   assign rd_addr = idx_ff[ADDR_W-1:0];

   always_comb begin
      active_in   = active_ff;
      pending_in  = rd_en;
      valid_in    = valid_ff;
      len_in      = len_ff;
      idx_in      = idx_ff;
      pend_pos_in = pend_pos_ff;
      byte_in     = byte_ff;
      pos_in      = pos_ff;
      len_out_in  = len_out_ff;
      last_in     = last_ff;
      if (valid_ff && out_ready) begin
         valid_in = 1'b0;
      end
      if (pending_ff) begin
         valid_in   = 1'b1;
         byte_in    = rd_data;
         pos_in     = pend_pos_ff;
         // length travels with the item, a new frame may start while it waits
         len_out_in = len_ff;
         last_in    = (LEN_W'(pend_pos_ff) + LEN_W'(1)) == len_ff;
      end
      if (rd_en) begin
         pend_pos_in = idx_ff[POS_W-1:0];
         idx_in      = idx_inc;
         if (idx_inc == len_ff) begin
            active_in = 1'b0;
         end
      end
      if (burst.start) begin
         active_in = 1'b1;
         len_in    = burst.length;
         idx_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         pending_ff <= 1'b0;
         valid_ff   <= 1'b0;
         len_ff     <= '0;
         idx_ff     <= '0;
      end else begin
         active_ff  <= active_in;
         pending_ff <= pending_in;
         valid_ff   <= valid_in;
         len_ff     <= len_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_pos_ff <= pend_pos_in;
      byte_ff     <= byte_in;
      pos_ff      <= pos_in;
      len_out_ff  <= len_out_in;
      last_ff     <= last_in;
   end

   assign busy      = active_ff;
   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_pos   = pos_ff;
   assign out_len   = len_out_ff;
   assign out_last  = last_ff;

`ifndef SYNTHESIS
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      burst.start |-> !active_ff)
      else $error("new burst while previous one still reading");

   a_pending_slot_free: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> !valid_ff)
      else $error("read data would overwrite an untaken result");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> idx_ff < len_ff)
      else $error("read index past frame length");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable({byte_ff, pos_ff, len_out_ff, last_ff}))
      else $error("waiting result changed before it was taken");
`endif

endmodule

// ===== sv/sync_length_checksum_deframer.sv =====
// top level of the sync, length and fletcher-style checksum deframer
//
//   channel  dir  handshake                 payload
//   req      in   req_tvalid / req_tready   req_tdata: rx_byte
//   rsp      out  rsp_tvalid / rsp_tready   rsp_tdata, rsp_tlast: payload item
//   csr      in   csr_valid / csr_ready     csr_index, csr_data: sync bytes
//
// one received byte is taken per cycle while no burst is being read out
// a frame that passes both checks is played out of the payload ram one item at a
//   time: the ram's registered read and the single result register allow only one
//   read in flight; req_tready is low from the edge that takes the second check byte
//   until the last ram read has been issued
// synchronous active-high reset clears the framing state and the burst reader;
//   the payload ram has no reset and no clearing pass
// a stalled rsp side holds the burst reader, and with it req_tready stays low
//   until the last ram read has gone; csr writes are always taken
module sync_length_checksum_deframer #(
   parameter int unsigned MAX_PAYLOAD = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // input bytes
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,  // [7:0] rx_byte
   // payload items
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [23:0]                      rsp_tdata,  // [7:0] payload_byte,
                                                        // [13:8] byte_position,
                                                        // [20:14] frame_length,
                                                        // [23:21] zero
   output logic                             rsp_tlast,  // last
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [slcd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [7:0]                       csr_data
);
   import slcd_pkg::*;

   localparam int unsigned ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   // sync byte registers
   logic [BYTE_W-1:0] sync_first_ff,  sync_first_in;
   logic [BYTE_W-1:0] sync_second_ff, sync_second_in;

   // ram ports
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;

   slcd_burst_type    burst;
   logic              busy;
   logic              req_fire;

   logic [BYTE_W-1:0] out_byte;
   logic [POS_W-1:0]  out_pos;
   logic [LEN_W-1:0]  out_len;

   assign csr_ready  = 1'b1;
   // input held off while the burst reader owns the ram's read side; the
   // receive side cannot reach a new payload write before the last read has gone
   assign req_tready = !busy;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SYNC_FIRST:  sync_first_in  = csr_data;
            CSR_SYNC_SECOND: sync_second_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= '0;
         sync_second_ff <= '0;
      end else begin
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
      end
   end

   // framing state machine and checksums, writes payload bytes into the ram
   slcd_rx #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .ADDR_W      (ADDR_W)
   ) u_rx (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_fire),
      .rx_byte     (req_tdata),
      .sync_first  (sync_first_ff),
      .sync_second (sync_second_ff),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .burst       (burst)
   );

   // payload buffer, one byte per entry
   slcd_ram #(
      .WIDTH  (BYTE_W),
      .DEPTH  (MAX_PAYLOAD),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // reads the frame back out once both check bytes have matched
   slcd_tx #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .ADDR_W      (ADDR_W)
   ) u_tx (
      .clock     (clock),
      .reset     (reset),
      .burst     (burst),
      .busy      (busy),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (out_byte),
      .out_pos   (out_pos),
      .out_len   (out_len),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, out_len, out_pos, out_byte};

`ifndef SYNTHESIS
   a_no_input_in_burst: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_fire)
      else $error("byte accepted during burst read-out");

   a_ram_ports_apart: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("payload write and burst read in the same cycle");

   a_burst_busy: assert property (@(posedge clock) disable iff (reset)
      burst.start |=> busy)
      else $error("matched frame did not start a burst");
`endif

endmodule

// ===== bench/deframer_check.sv =====
// checker for the deframer: tracks the framing, predicts payload items and compares them
module deframer_check #(
   parameter int unsigned MAX_PAYLOAD = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [7:0]                     req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [23:0]                    rsp_tdata,
   input  logic                           rsp_tlast,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [slcd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_data,
   output int                             err_count,
   output int                             due_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import slcd_pkg::*;

   typedef enum logic [2:0] {
      HUNT_FIRST, HUNT_SECOND, TAKE_LENGTH, TAKE_PAYLOAD, TAKE_CHECK_LOW, TAKE_CHECK_HIGH
   } hunt_phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [POS_W-1:0]  pos;
      logic [LEN_W-1:0]  len;
      logic              tlast;
   } payload_item_type;

   logic [7:0]       sync_first_q, sync_second_q;
   hunt_phase_type   phase_q;
   logic [LEN_W-1:0] frame_len, rx_count;
   logic [7:0]       sum_lo, sum_hi;
   logic [7:0]       held_bytes [MAX_PAYLOAD];
   payload_item_type payload_due [$];

   task automatic take_rx_byte(input logic [7:0] b);
      payload_item_type it;
      case (phase_q)
         HUNT_SECOND: phase_q = (b == sync_second_q) ? TAKE_LENGTH : HUNT_FIRST;
         TAKE_LENGTH: begin
            if (b == 8'd0 || b > MAX_PAYLOAD) begin
               phase_q = HUNT_FIRST;
            end else begin
               frame_len = b[LEN_W-1:0];
               rx_count  = '0;
               sum_lo    = b;
               sum_hi    = b;
               phase_q   = TAKE_PAYLOAD;
            end
         end
         TAKE_PAYLOAD: begin
            if (rx_count < MAX_PAYLOAD) held_bytes[rx_count] = b;
            rx_count = rx_count + 1'b1;
            sum_lo   = sum_lo + b;
            sum_hi   = sum_hi + sum_lo;
            if (rx_count >= frame_len) phase_q = TAKE_CHECK_LOW;
         end
         TAKE_CHECK_LOW: phase_q = (b == sum_lo) ? TAKE_CHECK_HIGH : HUNT_FIRST;
         TAKE_CHECK_HIGH: begin
            phase_q = HUNT_FIRST;
            if (b == sum_hi) begin
               // frame passed both sums: all frame_len held bytes are due as one run
               for (int k = 0; k < frame_len; k++) begin
                  it.data  = held_bytes[k];
                  it.pos   = k[POS_W-1:0];
                  it.len   = frame_len;
                  it.tlast = (k + 1 == frame_len);
                  payload_due.push_back(it);
               end
            end
         end
         default: phase_q = (b == sync_first_q) ? HUNT_SECOND : HUNT_FIRST;
      endcase
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: rsp %s expected %0d got %0d", $time, name, want, got);
         err_count++;
      end
   endtask

   initial begin
      err_count = 0;
      due_count = 0;
   end

   always @(posedge clock) begin
      payload_item_type want;
      if (reset) begin
         sync_first_q  = '0;
         sync_second_q = '0;
         phase_q       = HUNT_FIRST;
         frame_len     = '0;
         rx_count      = '0;
         sum_lo        = '0;
         sum_hi        = '0;
         payload_due.delete();
      end else begin
         // a byte taken at the same edge as a register write still sees the old value
         if (req_tvalid && req_tready) take_rx_byte(req_tdata);
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SYNC_FIRST) sync_first_q = csr_data;
            else if (csr_index == CSR_SYNC_SECOND) sync_second_q = csr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (payload_due.size() == 0) begin
               $display("%0t: rsp item 0x%06h last %0b arrived with nothing expected",
                        $time, rsp_tdata, rsp_tlast);
               err_count++;
            end else begin
               want = payload_due.pop_front();
               check_field("payload_byte", want.data, rsp_tdata[7:0]);
               check_field("byte_position", want.pos, rsp_tdata[13:8]);
               check_field("frame_length", want.len, rsp_tdata[20:14]);
               check_field("padding", 0, rsp_tdata[23:21]);
               check_field("tlast", want.tlast, rsp_tlast);
            end
         end
      end
      due_count = payload_due.size();
   end

endmodule

// ===== bench/tb_top.sv =====
// stimulus and verdict for the sync, length and checksum deframer
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import slcd_pkg::*;

   localparam int unsigned MAX_PAYLOAD  = 64;
   localparam int          PHASE_BYTES  = 50;    // frame bytes per sync setting
   localparam int          SETTLE_CYCLES = 150;  // wait after the last expected item has been taken
   localparam int          STALL_LIMIT  = 4000;  // cycles with no handshake on any channel

   typedef enum int {
      GOOD, BAD_SECOND_SYNC, BAD_LENGTH, BAD_CHECK_LOW, BAD_CHECK_HIGH, CUT_SHORT
   } frame_kind_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid, req_tready;
   logic [7:0]           req_tdata;
   logic                 rsp_tvalid, rsp_tready;
   logic [23:0]          rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [7:0]           csr_data;
   int                   err_count, due_count;

   // sync bytes as last written, used to build frames
   logic [7:0]           cfg_first, cfg_second;
   int                   sent_count;
   bit                   no_gaps;
   int                   quiet_cycles;

   sync_length_checksum_deframer #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] rx_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [7:0] payload_byte, [13:8] byte_position,
                                 // [20:14] frame_length, [23:21] zero
      .rsp_tlast  (rsp_tlast),   // last
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   deframer_check #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .err_count  (err_count),
      .due_count  (due_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // mostly short gaps, the odd long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // hold the byte until taken, then maybe idle; all changes on the falling edge
   task automatic send_byte(input logic [7:0] b);
      int gap;
      req_tdata  = b;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent_count++;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         req_tdata  = 8'($urandom);
         repeat (gap) @(negedge clock);
      end
   endtask

   // a frame, whole or spoilt in the way that kind names; fill < 0 gives random payload
   task automatic send_frame(input frame_kind_type kind, input int len, input int fill);
      logic [7:0] body [$];
      logic [7:0] lo, hi, bad;
      int         keep, k;
      lo = len[7:0];
      hi = len[7:0];
      for (k = 0; k < len; k++) begin
         body.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
         lo = lo + body[k];
         hi = hi + lo;
      end
      send_byte(cfg_first);
      if (kind == BAD_SECOND_SYNC) begin
         // half the time repeat the first sync byte, which must not restart the hunt
         if ($urandom_range(0, 1) == 1 && cfg_first != cfg_second) begin
            bad = cfg_first;
         end else begin
            do bad = 8'($urandom); while (bad == cfg_second);
         end
         send_byte(bad);
         return;
      end
      send_byte(cfg_second);
      if (kind == BAD_LENGTH) begin
         send_byte(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(65, 255)));
         return;
      end
      send_byte(len[7:0]);
      keep = (kind == CUT_SHORT) ? $urandom_range(0, len - 1) : len;
      for (k = 0; k < keep; k++) send_byte(body[k]);
      if (kind == CUT_SHORT) return;
      if (kind == BAD_CHECK_LOW) begin
         send_byte(lo ^ 8'($urandom_range(1, 255)));
         return;
      end
      send_byte(lo);
      send_byte(kind == BAD_CHECK_HIGH ? hi ^ 8'($urandom_range(1, 255)) : hi);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] value);
      csr_index = idx;
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // stop offering bytes, wait for the last burst, then give the block time to settle
   task automatic drain();
      req_tvalid = 1'b0;
      while (due_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // receiver: runs of ready, occasionally very long, broken by stalls
   initial begin
      int run, gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
         rsp_tready = 1'b1;
         repeat (run) @(negedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   // watchdog on handshakes of any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [7:0]     set_first [6];
      logic [7:0]     set_second [6];
      frame_kind_type kind;
      int             r, len, n, p;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_SYNC_FIRST;
      csr_data     = '0;
      cfg_first    = 8'h00;
      cfg_second   = 8'h00;
      sent_count   = 0;
      no_gaps      = 1'b0;
      quiet_cycles = 0;
      // setting 0 keeps the reset values, 1 is a fixed pattern, 2 to 4 cover the byte extremes, the last is random
      set_first  = '{8'h00, 8'hA5, 8'hFF, 8'h00, 8'hFF, 8'($urandom)};
      set_second = '{8'h00, 8'h5A, 8'hFF, 8'hFF, 8'h00, 8'($urandom)};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: shortest frame with an all-ones byte, a two-byte all-zero frame,
      // bad lengths at both ends, wrong second sync, each check byte wrong
      send_frame(GOOD, 1, 8'hFF);
      send_frame(GOOD, 2, 8'h00);
      send_byte(cfg_first);
      send_byte(cfg_second);
      send_byte(8'd0);
      send_byte(cfg_first);
      send_byte(cfg_second);
      send_byte(8'd65);
      send_frame(BAD_SECOND_SYNC, 1, -1);
      send_frame(BAD_CHECK_LOW, 1, -1);
      send_frame(BAD_CHECK_HIGH, 1, -1);

      for (p = 0; p < 6; p++) begin
         if (p > 0) begin
            drain();
            cfg_first  = set_first[p];
            cfg_second = set_second[p];
            // write order varies between settings
            if ($urandom_range(0, 1) == 1) begin
               write_csr(CSR_SYNC_FIRST, cfg_first);
               write_csr(CSR_SYNC_SECOND, cfg_second);
            end else begin
               write_csr(CSR_SYNC_SECOND, cfg_second);
               write_csr(CSR_SYNC_FIRST, cfg_first);
            end
         end
         sent_count = 0;
         // a full-size frame opens two of the settings
         if (p == 3 || p == 5) send_frame(GOOD, MAX_PAYLOAD, -1);
         while (sent_count < PHASE_BYTES) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            // stray bytes on the line between frames, not counted
            if ($urandom_range(0, 6) == 0) begin
               n = $urandom_range(1, 4);
               repeat (n) send_byte(8'($urandom));
               sent_count -= n;
            end
            r = $urandom_range(0, 99);
            len = (r < 80) ? $urandom_range(1, 8) :
                  (r < 96) ? $urandom_range(9, MAX_PAYLOAD - 1) : MAX_PAYLOAD;
            r = $urandom_range(0, 99);
            kind = (r < 68) ? GOOD :
                   (r < 74) ? BAD_SECOND_SYNC :
                   (r < 80) ? BAD_LENGTH :
                   (r < 86) ? BAD_CHECK_LOW :
                   (r < 92) ? BAD_CHECK_HIGH : CUT_SHORT;
            send_frame(kind, len, -1);
         end
      end

      req_tvalid = 1'b0;
      drain();
      if (err_count == 0 && due_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/slcd_pkg.sv
sv/slcd_ram.sv
sv/slcd_rx.sv
sv/slcd_tx.sv
sv/sync_length_checksum_deframer.sv
bench/deframer_check.sv
bench/tb_top.sv
